// ===== rtl/rc_drive_command_decoder_assert.svh =====
// Assertion macros for the drive command decoder.
`ifndef RC_DRIVE_COMMAND_DECODER_ASSERT_SVH
`define RC_DRIVE_COMMAND_DECODER_ASSERT_SVH

`ifndef SYNTHESIS
`define RCD_ASSERT(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("rcd assertion failed");
`define RCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rcd assertion failed");
`else
`define RCD_ASSERT(lbl, clk, rst_n, cond)
`define RCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/rcd_pkg.sv =====
// Shared types, codes and tables of the drive command decoder.
package rcd_pkg;

    localparam logic [7:0] CHAR_0 = 8'h30;
    localparam logic [7:0] CHAR_9 = 8'h39;
    localparam logic [7:0] CHAR_Q = 8'h71;
    localparam logic [7:0] CHAR_S = 8'h53;
    localparam logic [7:0] CHAR_D = 8'h44;
    localparam logic [7:0] CHAR_F = 8'h46;
    localparam logic [7:0] CHAR_B = 8'h42;
    localparam logic [7:0] CHAR_L = 8'h4C;
    localparam logic [7:0] CHAR_R = 8'h52;
    localparam logic [7:0] CHAR_G = 8'h47;
    localparam logic [7:0] CHAR_I = 8'h49;
    localparam logic [7:0] CHAR_H = 8'h48;
    localparam logic [7:0] CHAR_J = 8'h4A;
    localparam logic [7:0] CHAR_UPPER_V = 8'h56;
    localparam logic [7:0] CHAR_LOWER_V = 8'h76;
    localparam logic [7:0] CHAR_W = 8'h57;
    localparam logic [7:0] CHAR_U = 8'h55;

    localparam logic [6:0] SPEED_RESET = 7'd50;
    localparam logic [6:0] SPEED_MAX   = 7'd100;

    typedef enum logic [1:0] {
        DRV_NONE = 2'd0,
        DRV_STOP = 2'd1,
        DRV_FWD  = 2'd2,
        DRV_BACK = 2'd3
    } drive_t;

    typedef enum logic [1:0] {
        STEER_NONE  = 2'd0,
        STEER_STOP  = 2'd1,
        STEER_LEFT  = 2'd2,
        STEER_RIGHT = 2'd3
    } steer_t;

    typedef enum logic [1:0] {
        SENS_NONE  = 2'd0,
        SENS_FRONT = 2'd1,
        SENS_REAR  = 2'd2,
        SENS_STOP  = 2'd3
    } sensor_t;

    typedef enum logic [1:0] {
        SRCH_NONE  = 2'd0,
        SRCH_RIGHT = 2'd1,
        SRCH_LEFT  = 2'd2
    } search_t;

    typedef enum logic [1:0] {
        MOT_STOP = 2'd0,
        MOT_FWD  = 2'd1,
        MOT_BACK = 2'd2
    } motion_t;

    typedef struct packed {
        logic        func;
        logic [7:0]  cmd_char;
        logic [15:0] range_sample;
        logic        range_valid;
    } request_t;

    typedef struct packed {
        drive_t      drive_cmd;
        logic [6:0]  drive_duty;
        steer_t      steer_cmd;
        sensor_t     sensor_cmd;
        search_t     search_request;
        logic        obstacle_on;
    } result_t;

    function automatic logic [3:0] speed_index(input logic [6:0] speed);
        logic [3:0] idx;
        priority if (speed >= 7'd100) idx = 4'd10;
        else if (speed >= 7'd90) idx = 4'd9;
        else if (speed >= 7'd80) idx = 4'd8;
        else if (speed >= 7'd70) idx = 4'd7;
        else if (speed >= 7'd60) idx = 4'd6;
        else if (speed >= 7'd50) idx = 4'd5;
        else if (speed >= 7'd40) idx = 4'd4;
        else if (speed >= 7'd30) idx = 4'd3;
        else if (speed >= 7'd20) idx = 4'd2;
        else if (speed >= 7'd10) idx = 4'd1;
        else idx = 4'd0;
        return idx;
    endfunction

    function automatic logic [7:0] stop_dist(input logic [3:0] idx);
        logic [7:0] range_limit;
        unique case (idx)
            4'd0:    range_limit = 8'd2;
            4'd1:    range_limit = 8'd15;
            4'd2:    range_limit = 8'd40;
            4'd3:    range_limit = 8'd60;
            4'd4:    range_limit = 8'd80;
            4'd5:    range_limit = 8'd95;
            4'd6:    range_limit = 8'd110;
            4'd7:    range_limit = 8'd120;
            4'd8:    range_limit = 8'd130;
            4'd9:    range_limit = 8'd140;
            default: range_limit = 8'd150;
        endcase
        return range_limit;
    endfunction

    function automatic drive_t dir_cmd(input motion_t motion);
        drive_t drv;
        unique case (motion)
            MOT_FWD:  drv = DRV_FWD;
            MOT_BACK: drv = DRV_BACK;
            default:  drv = DRV_NONE;
        endcase
        return drv;
    endfunction

endpackage

// ===== rtl/rc_drive_command_decoder.sv =====
// Top level of the remote drive command decoder.
// One request enters per cycle unless a stalled result register backs up the input register;
// its result passes from the input register into the result register and is held there until
// taken. Decode and distance compare between the input register and the result register are
// combinational, with speed, motion, avoidance and sensor arming state updated as each request
// moves into the result register.
`include "rc_drive_command_decoder_assert.svh"

module rc_drive_command_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        func,
    input  logic [7:0]  cmd_char,
    input  logic [15:0] range_sample,
    input  logic        range_valid,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  drive_cmd,
    output logic [6:0]  drive_duty,
    output logic [1:0]  steer_cmd,
    output logic [1:0]  sensor_cmd,
    output logic [1:0]  search_request,
    output logic        obstacle_on
);

    rcd_pkg::request_t req, req_q;
    rcd_pkg::result_t  res, res_q;
    logic              req_valid;
    logic              advance;

    assign req.func         = func;
    assign req.cmd_char     = cmd_char;
    assign req.range_sample = range_sample;
    assign req.range_valid  = range_valid;

    assign advance = req_valid && (!out_valid || out_ready);

    rcd_in_stage u_in (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req       (req),
        .advance   (advance),
        .req_valid (req_valid),
        .req_q     (req_q)
    );

    rcd_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .req     (req_q),
        .res     (res)
    );

    rcd_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .res       (res),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .res_q     (res_q)
    );

    assign drive_cmd      = res_q.drive_cmd;
    assign drive_duty     = res_q.drive_duty;
    assign steer_cmd      = res_q.steer_cmd;
    assign sensor_cmd     = res_q.sensor_cmd;
    assign search_request = res_q.search_request;
    assign obstacle_on    = res_q.obstacle_on;

    `RCD_ASSERT(a_ready_when_empty, clk, rst_n, !out_valid |-> in_ready)

endmodule

// ===== rtl/rcd_in_stage.sv =====
// Input register of the drive command decoder.
module rcd_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  rcd_pkg::request_t req,
    input  logic              advance,
    output logic              req_valid,
    output rcd_pkg::request_t req_q
);

    logic              valid_reg;
    rcd_pkg::request_t req_reg;

    assign in_ready  = !valid_reg || advance;
    assign req_valid = valid_reg;
    assign req_q     = req_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_reg <= req;
        end
    end

endmodule

// ===== rtl/rcd_core.sv =====
// Command decode, obstacle check and drive state of the decoder.
`include "rc_drive_command_decoder_assert.svh"

module rcd_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  rcd_pkg::request_t req,
    output rcd_pkg::result_t  res
);

    logic [6:0]       speed_reg, speed_next;
    rcd_pkg::motion_t motion_reg, motion_next;
    logic             avoid_reg, avoid_next;
    logic             front_reg, front_next;
    logic             rear_reg, rear_next;
    logic [6:0]       digit;
    logic [15:0]      limit;

    assign digit = {3'b000, req.cmd_char[3:0]};
    assign limit = {8'h00, rcd_pkg::stop_dist(rcd_pkg::speed_index(speed_reg))};

    always_comb
    begin
        speed_next  = speed_reg;
        motion_next = motion_reg;
        avoid_next  = avoid_reg;
        front_next  = front_reg;
        rear_next   = rear_reg;
        res.drive_cmd      = rcd_pkg::DRV_NONE;
        res.steer_cmd      = rcd_pkg::STEER_NONE;
        res.sensor_cmd     = rcd_pkg::SENS_NONE;
        res.search_request = rcd_pkg::SRCH_NONE;
        if (!req.func)
        begin
            priority if (req.cmd_char == rcd_pkg::CHAR_Q)
            begin
                speed_next    = rcd_pkg::SPEED_MAX;
                res.drive_cmd = rcd_pkg::dir_cmd(motion_reg);
            end
            else if (req.cmd_char >= rcd_pkg::CHAR_0 && req.cmd_char <= rcd_pkg::CHAR_9)
            begin
                speed_next    = (digit << 3) + (digit << 1);
                res.drive_cmd = rcd_pkg::dir_cmd(motion_reg);
            end
            else
            begin
                unique case (req.cmd_char)
                    rcd_pkg::CHAR_S, rcd_pkg::CHAR_D:
                    begin
                        res.drive_cmd = rcd_pkg::DRV_STOP;
                        res.steer_cmd = rcd_pkg::STEER_STOP;
                        motion_next   = rcd_pkg::MOT_STOP;
                    end
                    rcd_pkg::CHAR_F:
                    begin
                        res.drive_cmd = rcd_pkg::DRV_FWD;
                        res.steer_cmd = rcd_pkg::STEER_STOP;
                        motion_next   = rcd_pkg::MOT_FWD;
                    end
                    rcd_pkg::CHAR_B:
                    begin
                        res.drive_cmd = rcd_pkg::DRV_BACK;
                        res.steer_cmd = rcd_pkg::STEER_STOP;
                        motion_next   = rcd_pkg::MOT_BACK;
                    end
                    rcd_pkg::CHAR_L:
                    begin
                        res.drive_cmd = rcd_pkg::DRV_STOP;
                        res.steer_cmd = rcd_pkg::STEER_LEFT;
                        motion_next   = rcd_pkg::MOT_STOP;
                    end
                    rcd_pkg::CHAR_R:
                    begin
                        res.drive_cmd = rcd_pkg::DRV_STOP;
                        res.steer_cmd = rcd_pkg::STEER_RIGHT;
                        motion_next   = rcd_pkg::MOT_STOP;
                    end
                    rcd_pkg::CHAR_G:
                    begin
                        res.drive_cmd = rcd_pkg::DRV_FWD;
                        res.steer_cmd = rcd_pkg::STEER_LEFT;
                        motion_next   = rcd_pkg::MOT_FWD;
                    end
                    rcd_pkg::CHAR_I:
                    begin
                        res.drive_cmd = rcd_pkg::DRV_FWD;
                        res.steer_cmd = rcd_pkg::STEER_RIGHT;
                        motion_next   = rcd_pkg::MOT_FWD;
                    end
                    rcd_pkg::CHAR_H:
                    begin
                        res.drive_cmd = rcd_pkg::DRV_BACK;
                        res.steer_cmd = rcd_pkg::STEER_LEFT;
                        motion_next   = rcd_pkg::MOT_BACK;
                    end
                    rcd_pkg::CHAR_J:
                    begin
                        res.drive_cmd = rcd_pkg::DRV_BACK;
                        res.steer_cmd = rcd_pkg::STEER_RIGHT;
                        motion_next   = rcd_pkg::MOT_BACK;
                    end
                    rcd_pkg::CHAR_UPPER_V: avoid_next = 1'b1;
                    rcd_pkg::CHAR_LOWER_V: avoid_next = 1'b0;
                    rcd_pkg::CHAR_W: res.search_request = rcd_pkg::SRCH_RIGHT;
                    rcd_pkg::CHAR_U: res.search_request = rcd_pkg::SRCH_LEFT;
                    default: ;
                endcase
            end
        end
        else if (avoid_reg)
        begin
            unique case (motion_reg)
                rcd_pkg::MOT_FWD, rcd_pkg::MOT_BACK:
                begin
                    if (motion_reg == rcd_pkg::MOT_FWD)
                    begin
                        if (front_reg)
                        begin
                            front_next     = 1'b0;
                            res.sensor_cmd = rcd_pkg::SENS_FRONT;
                        end
                    end
                    else if (rear_reg)
                    begin
                        rear_next      = 1'b0;
                        res.sensor_cmd = rcd_pkg::SENS_REAR;
                    end
                    if (req.range_valid && req.range_sample <= limit)
                    begin
                        res.drive_cmd = rcd_pkg::DRV_STOP;
                        res.steer_cmd = rcd_pkg::STEER_STOP;
                    end
                end
                default:
                begin
                    res.sensor_cmd = rcd_pkg::SENS_STOP;
                    front_next     = 1'b1;
                    rear_next      = 1'b1;
                end
            endcase
        end
        res.drive_duty  = (res.drive_cmd == rcd_pkg::DRV_FWD
                           || res.drive_cmd == rcd_pkg::DRV_BACK) ? speed_next : 7'd0;
        res.obstacle_on = avoid_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg  <= rcd_pkg::SPEED_RESET;
            motion_reg <= rcd_pkg::MOT_STOP;
            avoid_reg  <= 1'b0;
            front_reg  <= 1'b1;
            rear_reg   <= 1'b1;
        end
        else if (advance)
        begin
            speed_reg  <= speed_next;
            motion_reg <= motion_next;
            avoid_reg  <= avoid_next;
            front_reg  <= front_next;
            rear_reg   <= rear_next;
        end
    end

    `RCD_ASSERT(a_speed_range, clk, rst_n, speed_reg <= rcd_pkg::SPEED_MAX)
    `RCD_ASSERT_NEXT(a_state_hold, clk, rst_n, !advance, $stable(speed_reg) && $stable(motion_reg) && $stable(avoid_reg))
    `RCD_ASSERT_NEXT(a_front_disarm, clk, rst_n, advance && req.func && avoid_reg && motion_reg == rcd_pkg::MOT_FWD, !front_reg)

endmodule

// ===== rtl/rcd_out_stage.sv =====
// Result register of the drive command decoder.
module rcd_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  rcd_pkg::result_t res,
    input  logic             out_ready,
    output logic             out_valid,
    output rcd_pkg::result_t res_q
);

    logic             valid_reg;
    rcd_pkg::result_t res_reg;

    assign out_valid = valid_reg;
    assign res_q     = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res;
        end
    end

endmodule

// ===== bench/tb.sv =====
// Testbench for rc_drive_command_decoder: directed table plus random requests against a predictor.
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TIMEOUT_CYCLES   = 200000;
    localparam int RANDOM_PER_PHASE = 138;
    localparam int LONG_HOLD_CYCLES = 60;
    localparam int DRAIN_CYCLES     = 8;

    localparam int SEND_IDLE_PCT[4]  = '{0, 49, 0, 37};
    localparam int RECV_STALL_PCT[4] = '{0, 0, 49, 37};

    localparam logic [15:0] STOP_RANGE[11] =
        '{16'd2, 16'd15, 16'd40, 16'd60, 16'd80, 16'd95, 16'd110, 16'd120, 16'd130, 16'd140,
          16'd150};

    localparam logic [7:0] LETTERS[16] =
        '{rcd_pkg::CHAR_S, rcd_pkg::CHAR_D, rcd_pkg::CHAR_F, rcd_pkg::CHAR_B,
          rcd_pkg::CHAR_L, rcd_pkg::CHAR_R, rcd_pkg::CHAR_G, rcd_pkg::CHAR_I,
          rcd_pkg::CHAR_H, rcd_pkg::CHAR_J, rcd_pkg::CHAR_UPPER_V, rcd_pkg::CHAR_UPPER_V,
          rcd_pkg::CHAR_UPPER_V, rcd_pkg::CHAR_LOWER_V, rcd_pkg::CHAR_W, rcd_pkg::CHAR_U};

    localparam rcd_pkg::result_t QUIET_OFF =
        '{rcd_pkg::DRV_NONE, 7'd0, rcd_pkg::STEER_NONE, rcd_pkg::SENS_NONE,
          rcd_pkg::SRCH_NONE, 1'b0};
    localparam rcd_pkg::result_t QUIET_ON =
        '{rcd_pkg::DRV_NONE, 7'd0, rcd_pkg::STEER_NONE, rcd_pkg::SENS_NONE,
          rcd_pkg::SRCH_NONE, 1'b1};
    localparam rcd_pkg::result_t HALT_CHECK_ON =
        '{rcd_pkg::DRV_NONE, 7'd0, rcd_pkg::STEER_NONE, rcd_pkg::SENS_STOP,
          rcd_pkg::SRCH_NONE, 1'b1};
    localparam rcd_pkg::result_t SEARCH_RIGHT_ON =
        '{rcd_pkg::DRV_NONE, 7'd0, rcd_pkg::STEER_NONE, rcd_pkg::SENS_NONE,
          rcd_pkg::SRCH_RIGHT, 1'b1};
    localparam rcd_pkg::result_t SEARCH_LEFT_ON =
        '{rcd_pkg::DRV_NONE, 7'd0, rcd_pkg::STEER_NONE, rcd_pkg::SENS_NONE,
          rcd_pkg::SRCH_LEFT, 1'b1};

    typedef struct packed {
        rcd_pkg::request_t req;
        logic              fixed;
        rcd_pkg::result_t  res;
    } drive_case_t;

    logic        clk;
    logic        rst_n          = 1'b0;
    logic        in_valid       = 1'b0;
    logic        in_ready;
    logic        func           = 1'b0;
    logic [7:0]  cmd_char       = 8'd0;
    logic [15:0] range_sample   = 16'd0;
    logic        range_valid    = 1'b0;
    logic        out_valid;
    logic        out_ready      = 1'b0;
    logic [1:0]  drive_cmd;
    logic [6:0]  drive_duty;
    logic [1:0]  steer_cmd;
    logic [1:0]  sensor_cmd;
    logic [1:0]  search_request;
    logic        obstacle_on;

    logic [6:0]       speed_now;
    rcd_pkg::motion_t motion_now;
    logic             avoid_on;
    logic             front_armed;
    logic             rear_armed;

    rcd_pkg::result_t pending_results[$];
    drive_case_t      directed_cases[$];
    int               mismatch_count = 0;
    int               idle_pct       = 0;
    int               stall_pct      = 0;
    int               hold_off_req   = 0;

    rc_drive_command_decoder u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .func           (func),
        .cmd_char       (cmd_char),
        .range_sample   (range_sample),
        .range_valid    (range_valid),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .drive_cmd      (drive_cmd),
        .drive_duty     (drive_duty),
        .steer_cmd      (steer_cmd),
        .sensor_cmd     (sensor_cmd),
        .search_request (search_request),
        .obstacle_on    (obstacle_on)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic rcd_pkg::request_t remote_byte(input logic [7:0] c);
        rcd_pkg::request_t req;
        req = '0;
        req.cmd_char = c;
        return req;
    endfunction

    function automatic rcd_pkg::request_t range_tick(input logic [15:0] s, input logic v);
        rcd_pkg::request_t req;
        req = '0;
        req.func = 1'b1;
        req.range_sample = s;
        req.range_valid = v;
        return req;
    endfunction

    function automatic int range_index();
        return (speed_now >= 7'd100) ? 10 : int'(speed_now) / 10;
    endfunction

    function automatic rcd_pkg::result_t decode_drive_request(input rcd_pkg::request_t req);
        rcd_pkg::result_t res;
        res = QUIET_OFF;
        if (!req.func) begin
            if ((req.cmd_char >= rcd_pkg::CHAR_0 && req.cmd_char <= rcd_pkg::CHAR_9)
                || req.cmd_char == rcd_pkg::CHAR_Q)
            begin
                speed_now = (req.cmd_char == rcd_pkg::CHAR_Q)
                            ? rcd_pkg::SPEED_MAX
                            : 7'(int'(req.cmd_char - rcd_pkg::CHAR_0) * 10);
                if (motion_now == rcd_pkg::MOT_FWD)
                    res.drive_cmd = rcd_pkg::DRV_FWD;
                else if (motion_now == rcd_pkg::MOT_BACK)
                    res.drive_cmd = rcd_pkg::DRV_BACK;
            end
            else
            begin
                case (req.cmd_char)
                    rcd_pkg::CHAR_S, rcd_pkg::CHAR_D:
                    begin
                        res.drive_cmd = rcd_pkg::DRV_STOP;
                        res.steer_cmd = rcd_pkg::STEER_STOP;
                        motion_now = rcd_pkg::MOT_STOP;
                    end
                    rcd_pkg::CHAR_F:
                    begin
                        res.drive_cmd = rcd_pkg::DRV_FWD;
                        res.steer_cmd = rcd_pkg::STEER_STOP;
                        motion_now = rcd_pkg::MOT_FWD;
                    end
                    rcd_pkg::CHAR_B:
                    begin
                        res.drive_cmd = rcd_pkg::DRV_BACK;
                        res.steer_cmd = rcd_pkg::STEER_STOP;
                        motion_now = rcd_pkg::MOT_BACK;
                    end
                    rcd_pkg::CHAR_L, rcd_pkg::CHAR_R:
                    begin
                        res.drive_cmd = rcd_pkg::DRV_STOP;
                        res.steer_cmd = (req.cmd_char == rcd_pkg::CHAR_L)
                                        ? rcd_pkg::STEER_LEFT : rcd_pkg::STEER_RIGHT;
                        motion_now = rcd_pkg::MOT_STOP;
                    end
                    rcd_pkg::CHAR_G, rcd_pkg::CHAR_I:
                    begin
                        res.drive_cmd = rcd_pkg::DRV_FWD;
                        res.steer_cmd = (req.cmd_char == rcd_pkg::CHAR_G)
                                        ? rcd_pkg::STEER_LEFT : rcd_pkg::STEER_RIGHT;
                        motion_now = rcd_pkg::MOT_FWD;
                    end
                    rcd_pkg::CHAR_H, rcd_pkg::CHAR_J:
                    begin
                        res.drive_cmd = rcd_pkg::DRV_BACK;
                        res.steer_cmd = (req.cmd_char == rcd_pkg::CHAR_H)
                                        ? rcd_pkg::STEER_LEFT : rcd_pkg::STEER_RIGHT;
                        motion_now = rcd_pkg::MOT_BACK;
                    end
                    rcd_pkg::CHAR_UPPER_V: avoid_on = 1'b1;
                    rcd_pkg::CHAR_LOWER_V: avoid_on = 1'b0;
                    rcd_pkg::CHAR_W:       res.search_request = rcd_pkg::SRCH_RIGHT;
                    rcd_pkg::CHAR_U:       res.search_request = rcd_pkg::SRCH_LEFT;
                    default:               ;
                endcase
            end
        end
        else if (avoid_on)
        begin
            if (motion_now == rcd_pkg::MOT_FWD || motion_now == rcd_pkg::MOT_BACK)
            begin
                if (motion_now == rcd_pkg::MOT_FWD && front_armed)
                begin
                    front_armed = 1'b0;
                    res.sensor_cmd = rcd_pkg::SENS_FRONT;
                end
                else if (motion_now == rcd_pkg::MOT_BACK && rear_armed)
                begin
                    rear_armed = 1'b0;
                    res.sensor_cmd = rcd_pkg::SENS_REAR;
                end
                if (req.range_valid && req.range_sample <= STOP_RANGE[range_index()])
                begin
                    res.drive_cmd = rcd_pkg::DRV_STOP;
                    res.steer_cmd = rcd_pkg::STEER_STOP;
                end
            end
            else
            begin
                res.sensor_cmd = rcd_pkg::SENS_STOP;
                front_armed = 1'b1;
                rear_armed = 1'b1;
            end
        end
        if (res.drive_cmd == rcd_pkg::DRV_FWD || res.drive_cmd == rcd_pkg::DRV_BACK)
            res.drive_duty = speed_now;
        res.obstacle_on = avoid_on;
        return res;
    endfunction

    function automatic rcd_pkg::request_t random_request();
        rcd_pkg::request_t req;
        int                pick;
        int                near;
        pick = $urandom_range(0, 99);
        req.func = 1'b0;
        req.cmd_char = 8'($urandom_range(0, 255));
        req.range_sample = 16'($urandom_range(0, 65535));
        req.range_valid = 1'($urandom_range(0, 1));
        if (pick < 35)
        begin
            req.func = 1'b1;
            req.range_valid = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 4) < 3)
            begin
                near = int'(STOP_RANGE[range_index()]) + int'($urandom_range(0, 4)) - 2;
                req.range_sample = 16'(near);
            end
        end
        else if (pick < 52)
            req.cmd_char = ($urandom_range(0, 10) == 10)
                           ? rcd_pkg::CHAR_Q
                           : rcd_pkg::CHAR_0 + 8'($urandom_range(0, 9));
        else if (pick < 90)
            req.cmd_char = LETTERS[$urandom_range(0, 15)];
        return req;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_drive_result();
        rcd_pkg::result_t want;
        if (pending_results.size() == 0)
        begin
            report_mismatch("result arrived with no request pending");
            return;
        end
        want = pending_results.pop_front();
        if (drive_cmd !== want.drive_cmd)
            report_mismatch($sformatf("drive_cmd got %0d expected %0d", drive_cmd,
                                      want.drive_cmd));
        if (drive_duty !== want.drive_duty)
            report_mismatch($sformatf("drive_duty got %0d expected %0d", drive_duty,
                                      want.drive_duty));
        if (steer_cmd !== want.steer_cmd)
            report_mismatch($sformatf("steer_cmd got %0d expected %0d", steer_cmd,
                                      want.steer_cmd));
        if (sensor_cmd !== want.sensor_cmd)
            report_mismatch($sformatf("sensor_cmd got %0d expected %0d", sensor_cmd,
                                      want.sensor_cmd));
        if (search_request !== want.search_request)
            report_mismatch($sformatf("search_request got %0d expected %0d", search_request,
                                      want.search_request));
        if (obstacle_on !== want.obstacle_on)
            report_mismatch($sformatf("obstacle_on got %0d expected %0d", obstacle_on,
                                      want.obstacle_on));
    endtask

    task automatic offer_request(input rcd_pkg::request_t req, input logic fixed,
                                 input rcd_pkg::result_t fixed_res);
        rcd_pkg::result_t predicted;
        predicted = decode_drive_request(req);
        pending_results.push_back(fixed ? fixed_res : predicted);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        func         <= req.func;
        cmd_char     <= req.cmd_char;
        range_sample <= req.range_sample;
        range_valid  <= req.range_valid;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic wait_results_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Receive side: check results, random stalls and requested long hold-offs.
    initial
    begin
        int hold_left;
        hold_left = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                check_drive_result();
            if (hold_off_req > 0)
            begin
                hold_left = hold_off_req;
                hold_off_req = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    initial
    begin
        repeat (TIMEOUT_CYCLES) @(posedge clk);
        $display("tb: FAIL");
        $finish;
    end

    initial
    begin
        speed_now   = rcd_pkg::SPEED_RESET;
        motion_now  = rcd_pkg::MOT_STOP;
        avoid_on    = 1'b0;
        front_armed = 1'b1;
        rear_armed  = 1'b1;

        directed_cases = '{
            '{range_tick(16'd0, 1'b1),               1'b1, QUIET_OFF},
            '{remote_byte(8'hFF),                    1'b1, QUIET_OFF},
            '{remote_byte(8'h00),                    1'b1, QUIET_OFF},
            '{remote_byte(rcd_pkg::CHAR_9),          1'b1, QUIET_OFF},
            '{remote_byte(rcd_pkg::CHAR_UPPER_V),    1'b1, QUIET_ON},
            '{range_tick(16'hFFFF, 1'b1),            1'b1, HALT_CHECK_ON},
            '{remote_byte(rcd_pkg::CHAR_F),          1'b0, QUIET_OFF},
            '{range_tick(16'd141, 1'b1),             1'b0, QUIET_OFF},
            '{range_tick(16'd140, 1'b1),             1'b0, QUIET_OFF},
            '{range_tick(16'd0, 1'b0),               1'b0, QUIET_OFF},
            '{remote_byte(rcd_pkg::CHAR_Q),          1'b0, QUIET_OFF},
            '{range_tick(16'd150, 1'b1),             1'b0, QUIET_OFF},
            '{remote_byte(rcd_pkg::CHAR_0),          1'b0, QUIET_OFF},
            '{range_tick(16'd2, 1'b1),               1'b0, QUIET_OFF},
            '{remote_byte(rcd_pkg::CHAR_B),          1'b0, QUIET_OFF},
            '{range_tick(16'hFFFF, 1'b1),            1'b0, QUIET_OFF},
            '{remote_byte(rcd_pkg::CHAR_H),          1'b0, QUIET_OFF},
            '{remote_byte(rcd_pkg::CHAR_J),          1'b0, QUIET_OFF},
            '{remote_byte(rcd_pkg::CHAR_G),          1'b0, QUIET_OFF},
            '{remote_byte(rcd_pkg::CHAR_I),          1'b0, QUIET_OFF},
            '{remote_byte(rcd_pkg::CHAR_W),          1'b1, SEARCH_RIGHT_ON},
            '{remote_byte(rcd_pkg::CHAR_U),          1'b1, SEARCH_LEFT_ON},
            '{remote_byte(rcd_pkg::CHAR_L),          1'b0, QUIET_OFF},
            '{remote_byte(rcd_pkg::CHAR_R),          1'b0, QUIET_OFF},
            '{remote_byte(rcd_pkg::CHAR_LOWER_V),    1'b1, QUIET_OFF},
            '{remote_byte(rcd_pkg::CHAR_S),          1'b0, QUIET_OFF},
            '{remote_byte(rcd_pkg::CHAR_D),          1'b0, QUIET_OFF},
            '{range_tick(16'd0, 1'b1),               1'b1, QUIET_OFF}
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_cases[i])
            offer_request(directed_cases[i].req, directed_cases[i].fixed, directed_cases[i].res);
        wait_results_drained();

        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct  = SEND_IDLE_PCT[ph];
            stall_pct = RECV_STALL_PCT[ph];
            if (ph == 0)
                hold_off_req = LONG_HOLD_CYCLES;
            repeat (RANDOM_PER_PHASE)
                offer_request(random_request(), 1'b0, QUIET_OFF);
            wait_results_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/rcd_pkg.sv
rtl/rcd_in_stage.sv
rtl/rcd_core.sv
rtl/rcd_out_stage.sv
rtl/rc_drive_command_decoder.sv
bench/tb.sv
